[src/thp_pkg.sv]
// Shared types, register codes and constants for the sensor compensation pipeline.
// No dependencies; every other file imports this package.
`default_nettype none
package thp_pkg;

	// Register map
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_TEMP  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PLOW  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PHIGH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_P9    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HUM   = 3'd4;

	// One quotient bit per divider stage
	localparam int DIV_STAGES = 64;

	// Formula constants
	localparam logic signed [32:0] TFINE_OFS_P = 33'sd128000;
	localparam logic signed [63:0] P_DIV_SCALE = 64'sd3125;
	localparam logic [20:0]        P_ADC_FULL  = 21'd1048576;
	localparam logic signed [63:0] P_X_BIAS    = 64'sh0000_8000_0000_0000;
	localparam logic signed [31:0] TFINE_OFS_H = 32'sd76800;
	localparam logic signed [31:0] HUM_RND     = 32'sd16384;
	localparam logic signed [31:0] HUM_M_OFS   = 32'sd32768;
	localparam logic signed [31:0] HUM_W_OFS   = 32'sd2097152;
	localparam logic signed [31:0] HUM_W_RND   = 32'sd8192;
	localparam logic signed [31:0] HUM_MAX     = 32'sd419430400;
	localparam logic [16:0]        HUM_OUT_MAX = 17'd102400;
	localparam logic signed [31:0] TEMP_RND    = 32'sd128;

	typedef struct packed {
		logic [19:0] raw_temperature;
		logic [19:0] raw_pressure;
		logic [15:0] raw_humidity;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] temperature;
		logic [31:0]        pressure;
		logic [16:0]        humidity;
		logic               pressure_div_zero;
	} out_item_t;

	// Unpacked calibration coefficients
	typedef struct packed {
		logic [15:0]        t1;
		logic signed [15:0] t2;
		logic signed [15:0] t3;
		logic [15:0]        p1;
		logic signed [15:0] p2;
		logic signed [15:0] p3;
		logic signed [15:0] p4;
		logic signed [15:0] p5;
		logic signed [15:0] p6;
		logic signed [15:0] p7;
		logic signed [15:0] p8;
		logic signed [15:0] p9;
		logic [7:0]         h1;
		logic signed [15:0] h2;
		logic [7:0]         h3;
		logic signed [11:0] h4;
		logic signed [11:0] h5;
		logic signed [7:0]  h6;
	} coeff_t;

	// Side band that rides along the divider
	typedef struct packed {
		logic signed [31:0] temperature;
		logic [16:0]        humidity;
		logic               dz;
		logic               qneg;
	} side_t;

endpackage
`default_nettype wire

[src/thp_temp.sv]
// Temperature front end: three stages from raw reading to fine temperature.
// Depends on thp_pkg.
`default_nettype none
module thp_temp import thp_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               vld,
	input  wire in_item_t           item,
	input  wire coeff_t             cf,
	output logic                    vld_out,
	output logic signed [31:0]      tfine,
	output logic [19:0]             raw_p,
	output logic [15:0]             raw_h
);

	logic vld_s1, vld_s2, vld_s3;
	logic signed [31:0] aprod_s1, dd_s1, a_s2, b1_s2, tfine_s3;
	logic [19:0] rawp_s1, rawp_s2, rawp_s3;
	logic [15:0] rawh_s1, rawh_s2, rawh_s3;

	logic signed [31:0] aprod_c, dd_c, a_c, b1_c;

	// Stage 1: linear and square terms
	always_comb begin
		logic signed [31:0] adc, t1x, diff, dv;
		adc     = signed'({12'd0, item.raw_temperature});
		t1x     = signed'({16'd0, cf.t1});
		diff    = (adc >>> 3) - (t1x <<< 1);
		aprod_c = diff * 32'(cf.t2);
		dv      = (adc >>> 4) - t1x;
		dd_c    = dv * dv;
	end

	// Stage 2: scale and cubic coefficient
	always_comb begin
		a_c  = aprod_s1 >>> 11;
		b1_c = (dd_s1 >>> 12) * 32'(cf.t3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			aprod_s1 <= aprod_c;
			dd_s1    <= dd_c;
			rawp_s1  <= item.raw_pressure;
			rawh_s1  <= item.raw_humidity;
			a_s2     <= a_c;
			b1_s2    <= b1_c;
			rawp_s2  <= rawp_s1;
			rawh_s2  <= rawh_s1;
			tfine_s3 <= a_s2 + (b1_s2 >>> 14);
			rawp_s3  <= rawp_s2;
			rawh_s3  <= rawh_s2;
		end
	end

	assign vld_out = vld_s3;
	assign tfine   = tfine_s3;
	assign raw_p   = rawp_s3;
	assign raw_h   = rawh_s3;

endmodule
`default_nettype wire

[src/thp_hum.sv]
// Humidity path: six stages of 32-bit arithmetic from fine temperature to clamped Q7.10.
// Depends on thp_pkg.
`default_nettype none
module thp_hum import thp_pkg::*; (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic signed [31:0] tfine,
	input  wire logic [15:0]        raw_h,
	input  wire coeff_t             cf,
	output logic [16:0]             humidity
);

	logic signed [31:0] g_s1, k_s1, m_s1;
	logic signed [31:0] g_s2, km_s2;
	logic signed [31:0] g_s3, wh_s3;
	logic signed [31:0] vv_s4;
	logic signed [31:0] vv_s5, ss_s5;
	logic [16:0]        hum_s6;

	logic signed [31:0] g_c, k_c, m_c, km_c, wh_c, vv_c, ss_c;
	logic [16:0]        hum_c;

	// Stage 1: products of the offset temperature
	always_comb begin
		logic signed [31:0] v;
		v   = tfine - TFINE_OFS_H;
		g_c = ((signed'({16'd0, raw_h}) <<< 14) - (32'(cf.h4) <<< 20)
			- (v * 32'(cf.h5)) + HUM_RND) >>> 15;
		k_c = v * 32'(cf.h6);
		m_c = v * signed'({24'd0, cf.h3});
	end

	// Stage 2..5: chained scale factors
	always_comb begin
		km_c = (k_s1 >>> 10) * ((m_s1 >>> 11) + HUM_M_OFS);
		wh_c = (((km_s2 >>> 10) + HUM_W_OFS) * 32'(cf.h2)) + HUM_W_RND;
		vv_c = g_s3 * (wh_s3 >>> 14);
		ss_c = (vv_s4 >>> 15) * (vv_s4 >>> 15);
	end

	// Stage 6: correction and clamp
	always_comb begin
		logic signed [31:0] vf, vc;
		vf = vv_s5 - (((ss_s5 >>> 7) * signed'({24'd0, cf.h1})) >>> 4);
		if (vf[31])
			vc = '0;
		else if (vf > HUM_MAX)
			vc = HUM_MAX;
		else
			vc = vf;
		hum_c = vc[28:12];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			g_s1   <= g_c;
			k_s1   <= k_c;
			m_s1   <= m_c;
			g_s2   <= g_s1;
			km_s2  <= km_c;
			g_s3   <= g_s2;
			wh_s3  <= wh_c;
			vv_s4  <= vv_c;
			vv_s5  <= vv_s4;
			ss_s5  <= ss_c;
			hum_s6 <= hum_c;
		end
	end

	assign humidity = hum_s6;

endmodule
`default_nettype wire

[src/thp_pfront.sv]
// Pressure front end: six stages from fine temperature to divider operands.
// Also finishes the temperature output. Depends on thp_pkg.
`default_nettype none
module thp_pfront import thp_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               vld,
	input  wire logic signed [31:0] tfine,
	input  wire logic [19:0]        raw_p,
	input  wire coeff_t             cf,
	output logic                    vld_out,
	output logic [63:0]             num_abs,
	output logic [63:0]             den_abs,
	output logic                    qneg,
	output logic                    dz,
	output logic signed [31:0]      temperature
);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic signed [31:0] temp_s1, temp_s2, temp_s3, temp_s4, temp_s5, temp_s6;
	logic signed [63:0] xx_s1, xp5_s1, xp2_s1;
	logic [20:0]        padc_s1, padc_s2, padc_s3;
	logic signed [63:0] ya_s2, xxp3_s2, xp5_s2, xp2_s2;
	logic signed [63:0] y_s3, xs_s3;
	logic signed [63:0] xm_s4, npre_s4;
	logic signed [63:0] den_s5, num_s5;
	logic [63:0]        an_s6, ad_s6;
	logic               qneg_s6, dz_s6;

	logic signed [63:0] xx_c, xp5_c, xp2_c, ya_c, xxp3_c, y_c, xs_c, xm_c, npre_c;
	logic signed [31:0] temp_c;

	// Stage 1: offset temperature products, final temperature
	always_comb begin
		logic signed [32:0] x;
		x      = 33'(tfine) - TFINE_OFS_P;
		xx_c   = 64'(x) * 64'(x);
		xp5_c  = 64'(x) * 64'(cf.p5);
		xp2_c  = 64'(x) * 64'(cf.p2);
		temp_c = (tfine + (tfine <<< 2) + TEMP_RND) >>> 8;
	end

	// Stage 2..4: coefficient products and sums
	always_comb begin
		ya_c   = xx_s1 * 64'(cf.p6);
		xxp3_c = xx_s1 * 64'(cf.p3);
		y_c    = ya_s2 + (xp5_s2 <<< 17) + (64'(cf.p4) <<< 35);
		xs_c   = (xxp3_s2 >>> 8) + (xp2_s2 <<< 12);
		xm_c   = (P_X_BIAS + xs_s3) * signed'({48'd0, cf.p1});
		npre_c = signed'(64'(padc_s3) << 31) - y_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xx_s1   <= xx_c;
			xp5_s1  <= xp5_c;
			xp2_s1  <= xp2_c;
			padc_s1 <= P_ADC_FULL - 21'(raw_p);
			temp_s1 <= temp_c;
			ya_s2   <= ya_c;
			xxp3_s2 <= xxp3_c;
			xp5_s2  <= xp5_s1;
			xp2_s2  <= xp2_s1;
			padc_s2 <= padc_s1;
			temp_s2 <= temp_s1;
			y_s3    <= y_c;
			xs_s3   <= xs_c;
			padc_s3 <= padc_s2;
			temp_s3 <= temp_s2;
			xm_s4   <= xm_c;
			npre_s4 <= npre_c;
			temp_s4 <= temp_s3;
			// divisor and scaled dividend
			den_s5  <= xm_s4 >>> 33;
			num_s5  <= npre_s4 * P_DIV_SCALE;
			temp_s5 <= temp_s4;
			// magnitudes and quotient sign
			an_s6   <= num_s5[63] ? unsigned'(-num_s5) : unsigned'(num_s5);
			ad_s6   <= den_s5[63] ? unsigned'(-den_s5) : unsigned'(den_s5);
			qneg_s6 <= num_s5[63] ^ den_s5[63];
			dz_s6   <= (den_s5 == '0);
			temp_s6 <= temp_s5;
		end
	end

	assign vld_out     = vld_s6;
	assign num_abs     = an_s6;
	assign den_abs     = ad_s6;
	assign qneg        = qneg_s6;
	assign dz          = dz_s6;
	assign temperature = temp_s6;

endmodule
`default_nettype wire

[src/thp_div.sv]
// Pipelined restoring divider: one quotient bit per stage, 64 stages, unsigned operands.
// Carries the side band of each item alongside. Depends on thp_pkg.
`default_nettype none
module thp_div import thp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        en,
	input  wire logic        vld,
	input  wire logic [63:0] num,
	input  wire logic [63:0] den,
	input  wire side_t       side,
	output logic             vld_out,
	output logic [63:0]      quo,
	output side_t            side_out
);

	logic        vld_s  [1:DIV_STAGES];
	logic [63:0] rem_s  [1:DIV_STAGES];
	logic [63:0] nq_s   [1:DIV_STAGES];
	logic [63:0] den_s  [1:DIV_STAGES];
	side_t       side_s [1:DIV_STAGES];

	for (genvar i = 0; i < DIV_STAGES; i++) begin : g_step
		logic        vld_c;
		logic [63:0] rem_c, nq_c, den_c;
		side_t       side_c;
		logic [64:0] trial, diff;

		if (i == 0) begin : g_first
			assign vld_c  = vld;
			assign rem_c  = '0;
			assign nq_c   = num;
			assign den_c  = den;
			assign side_c = side;
		end else begin : g_next
			assign vld_c  = vld_s[i];
			assign rem_c  = rem_s[i];
			assign nq_c   = nq_s[i];
			assign den_c  = den_s[i];
			assign side_c = side_s[i];
		end

		// Shift in next dividend bit, subtract when it fits
		assign trial = {rem_c, nq_c[63]};
		assign diff  = trial - {1'b0, den_c};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[i+1] <= 1'b0;
			else if (en)
				vld_s[i+1] <= vld_c;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1]  <= diff[64] ? trial[63:0] : diff[63:0];
				nq_s[i+1]   <= {nq_c[62:0], ~diff[64]};
				den_s[i+1]  <= den_c;
				side_s[i+1] <= side_c;
			end
		end
	end

	assign vld_out  = vld_s[DIV_STAGES];
	assign quo      = nq_s[DIV_STAGES];
	assign side_out = side_s[DIV_STAGES];

endmodule
`default_nettype wire

[src/thp_pback.sv]
// Pressure back end: five stages from quotient to the finished result beat.
// Depends on thp_pkg.
`default_nettype none
module thp_pback import thp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        en,
	input  wire logic        vld,
	input  wire logic [63:0] quo,
	input  wire side_t       side,
	input  wire coeff_t      cf,
	output logic             vld_out,
	output out_item_t        item
);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	side_t side_s1, side_s2, side_s3, side_s4;
	logic signed [63:0] p_s1, p_s2, p_s3, p_s4;
	logic signed [63:0] q13_s2, pq_s2, f_s2, f_s3;
	logic [63:0]        ll_s3;
	logic [31:0]        c1_s3, c2_s3;
	logic signed [63:0] e_s4, fsh_s4;
	out_item_t          item_s5;

	logic signed [63:0] q13_c, pq_c, f_c;
	out_item_t          item_c;

	// Stage 2: first products
	always_comb begin
		q13_c = p_s1 >>> 13;
		pq_c  = 64'(cf.p9) * q13_c;
		f_c   = 64'(cf.p8) * p_s1;
	end

	// Stage 5: final sum and zero-divisor override
	always_comb begin
		logic signed [63:0] r;
		r = ((p_s4 + e_s4 + fsh_s4) >>> 8) + (64'(cf.p7) <<< 4);
		item_c.temperature       = side_s4.temperature;
		item_c.humidity          = side_s4.humidity;
		item_c.pressure_div_zero = side_s4.dz;
		item_c.pressure          = side_s4.dz ? '0 : r[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// restore quotient sign
			p_s1    <= side.qneg ? signed'(64'd0 - quo) : signed'(quo);
			side_s1 <= side;
			q13_s2  <= q13_c;
			pq_s2   <= pq_c;
			f_s2    <= f_c;
			p_s2    <= p_s1;
			side_s2 <= side_s1;
			// 64x64 low product split in 32-bit halves
			ll_s3   <= {32'd0, pq_s2[31:0]} * {32'd0, q13_s2[31:0]};
			c1_s3   <= pq_s2[31:0] * q13_s2[63:32];
			c2_s3   <= pq_s2[63:32] * q13_s2[31:0];
			f_s3    <= f_s2;
			p_s3    <= p_s2;
			side_s3 <= side_s2;
			e_s4    <= signed'(ll_s3 + {c1_s3 + c2_s3, 32'd0}) >>> 25;
			fsh_s4  <= f_s3 >>> 19;
			p_s4    <= p_s3;
			side_s4 <= side_s3;
			item_s5 <= item_c;
		end
	end

	assign vld_out = vld_s5;
	assign item    = item_s5;

endmodule
`default_nettype wire

[src/thp_sensor_compensation.sv]
// Path from an accepted input beat to out_valid, with no output stall:
// 78 pipeline stages plus the output buffer register.
// Throughput: one beat per cycle while the buffer has room; 78 stages, 64 in the divider.
// A two-entry output buffer lets the input keep flowing while one result waits.
// Reset clears all stage valid bits, the output buffer count and the coefficient registers.
// Top level: coefficient registers, stall control, output buffer.
// Depends on thp_pkg, thp_temp, thp_hum, thp_pfront, thp_div, thp_pback.
`default_nettype none
module thp_sensor_compensation import thp_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_write,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [63:0]          cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire in_item_t             in_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output out_item_t                 out_data
);

	logic [47:0] temp_q;
	logic [63:0] plow_q, phigh_q, hum_q;
	logic [15:0] p9_q;
	coeff_t      cf;

	logic               en;
	logic               t_vld, f_vld, d_vld, b_vld;
	logic signed [31:0] tfine, f_temp;
	logic [19:0]        raw_p;
	logic [15:0]        raw_h;
	logic [16:0]        hum;
	logic [63:0]        num_abs, den_abs, quo;
	logic               qneg, dz;
	side_t              side_in, side_out;
	out_item_t          b_item;

	logic [1:0] cnt_q;
	out_item_t  buf0_q, buf1_q;
	logic       push, pop, wr0, wr1;

	// Coefficient registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_q  <= '0;
			plow_q  <= '0;
			phigh_q <= '0;
			p9_q    <= '0;
			hum_q   <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_TEMP:  temp_q  <= cfg_data[47:0];
				REG_PLOW:  plow_q  <= cfg_data;
				REG_PHIGH: phigh_q <= cfg_data;
				REG_P9:    p9_q    <= cfg_data[15:0];
				REG_HUM:   hum_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Field unpacking
	always_comb begin
		cf.t1 = temp_q[15:0];
		cf.t2 = temp_q[31:16];
		cf.t3 = temp_q[47:32];
		cf.p1 = plow_q[15:0];
		cf.p2 = plow_q[31:16];
		cf.p3 = plow_q[47:32];
		cf.p4 = plow_q[63:48];
		cf.p5 = phigh_q[15:0];
		cf.p6 = phigh_q[31:16];
		cf.p7 = phigh_q[47:32];
		cf.p8 = phigh_q[63:48];
		cf.p9 = p9_q;
		cf.h1 = hum_q[7:0];
		cf.h2 = hum_q[23:8];
		cf.h3 = hum_q[31:24];
		cf.h4 = hum_q[43:32];
		cf.h5 = hum_q[55:44];
		cf.h6 = hum_q[63:56];
	end

	// Whole pipeline advances while the output buffer has room
	assign en       = (cnt_q != 2'd2);
	assign in_ready = en;

	thp_temp u_temp (
		.clk(clk), .arst_n(arst_n), .en(en), .vld(in_valid && en), .item(in_data), .cf(cf),
		.vld_out(t_vld), .tfine(tfine), .raw_p(raw_p), .raw_h(raw_h)
	);

	thp_hum u_hum (
		.clk(clk), .en(en), .tfine(tfine), .raw_h(raw_h), .cf(cf), .humidity(hum)
	);

	thp_pfront u_pfront (
		.clk(clk), .arst_n(arst_n), .en(en), .vld(t_vld), .tfine(tfine), .raw_p(raw_p),
		.cf(cf), .vld_out(f_vld), .num_abs(num_abs), .den_abs(den_abs), .qneg(qneg),
		.dz(dz), .temperature(f_temp)
	);

	always_comb begin
		side_in.temperature = f_temp;
		side_in.humidity    = hum;
		side_in.dz          = dz;
		side_in.qneg        = qneg;
	end

	thp_div u_div (
		.clk(clk), .arst_n(arst_n), .en(en), .vld(f_vld), .num(num_abs), .den(den_abs),
		.side(side_in), .vld_out(d_vld), .quo(quo), .side_out(side_out)
	);

	thp_pback u_pback (
		.clk(clk), .arst_n(arst_n), .en(en), .vld(d_vld), .quo(quo), .side(side_out),
		.cf(cf), .vld_out(b_vld), .item(b_item)
	);

	// Two-entry output buffer
	assign push = en && b_vld;
	assign pop  = out_valid && out_ready;
	assign wr0  = push && ((cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop));
	assign wr1  = push && (((cnt_q == 2'd1) && !pop) || ((cnt_q == 2'd2) && pop));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= '0;
		else
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
	end

	always_ff @(posedge clk) begin
		if (wr0)
			buf0_q <= b_item;
		else if (pop)
			buf0_q <= buf1_q;
		if (wr1)
			buf1_q <= b_item;
	end

	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = buf0_q;

	// Checks
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("output buffer count overflow");

	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.pressure_div_zero |-> out_data.pressure == '0)
		else $error("pressure not zero on zero divisor");

	a_hum_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.humidity <= HUM_OUT_MAX)
		else $error("humidity above clamp");

	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 && !out_ready |=> cnt_q == 2'd2)
		else $error("full buffer changed without a pop");

endmodule
`default_nettype wire

[test/tb.sv]
// Self-checking bench for thp_sensor_compensation: directed table, then random samples.
// Predicts results with a compensation model or typed rows; depends on thp_pkg and the RTL.
module tb;
	import thp_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_RANDOM  = 480;
	localparam int LATENCY   = 79;
	localparam int MAX_CYCLE = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [63:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;

	thp_sensor_compensation i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_write(cfg_write), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Calibration shadow
	logic [47:0] temp_cal;
	logic [63:0] plow_cal, phigh_cal, hum_cal;
	logic [15:0] p9_cal;

	out_item_t sample_q[$];
	int errors = 0;
	int n_beats = 0;
	int n_checked = 0;
	int n_dz = 0;
	int cycles = 0;
	int send_idle = 34;
	int recv_idle = 75;
	bit hold_off = 1'b0;

	function automatic logic [31:0] asr32(logic [31:0] x, int n);
		return $unsigned($signed(x) >>> n);
	endfunction

	function automatic logic [63:0] asr64(logic [63:0] x, int n);
		return $unsigned($signed(x) >>> n);
	endfunction

	// Compensation of one sample with the current calibration
	function automatic out_item_t compensate(in_item_t s);
		logic [31:0] t1, t2, t3, h1, h2, h3, h4, h5, h6;
		logic [31:0] a, d, b, tfine, v, g, k, m, w, sq;
		logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
		logic [63:0] x, y, p, q, e, f, an, ad, qq;
		out_item_t r;
		t1 = {16'd0, temp_cal[15:0]};
		t2 = {{16{temp_cal[31]}}, temp_cal[31:16]};
		t3 = {{16{temp_cal[47]}}, temp_cal[47:32]};
		p1 = {48'd0, plow_cal[15:0]};
		p2 = {{48{plow_cal[31]}}, plow_cal[31:16]};
		p3 = {{48{plow_cal[47]}}, plow_cal[47:32]};
		p4 = {{48{plow_cal[63]}}, plow_cal[63:48]};
		p5 = {{48{phigh_cal[15]}}, phigh_cal[15:0]};
		p6 = {{48{phigh_cal[31]}}, phigh_cal[31:16]};
		p7 = {{48{phigh_cal[47]}}, phigh_cal[47:32]};
		p8 = {{48{phigh_cal[63]}}, phigh_cal[63:48]};
		p9 = {{48{p9_cal[15]}}, p9_cal};
		h1 = {24'd0, hum_cal[7:0]};
		h2 = {{16{hum_cal[23]}}, hum_cal[23:8]};
		h3 = {24'd0, hum_cal[31:24]};
		h4 = {{20{hum_cal[43]}}, hum_cal[43:32]};
		h5 = {{20{hum_cal[55]}}, hum_cal[55:44]};
		h6 = {{24{hum_cal[63]}}, hum_cal[63:56]};
		// temperature
		a = asr32((({12'd0, s.raw_temperature} >> 3) - (t1 << 1)) * t2, 11);
		d = ({12'd0, s.raw_temperature} >> 4) - t1;
		b = asr32(asr32(d * d, 12) * t3, 14);
		tfine = a + b;
		r.temperature = asr32(tfine * 32'd5 + 32'd128, 8);
		// pressure
		x = {{32{tfine[31]}}, tfine} - 64'd128000;
		y = x * x * p6;
		y = y + ((x * p5) << 17);
		y = y + (p4 << 35);
		x = asr64(x * x * p3, 8) + ((x * p2) << 12);
		x = asr64(((64'd1 << 47) + x) * p1, 33);
		r.pressure = '0;
		r.pressure_div_zero = (x == 64'd0);
		if (x != 64'd0) begin
			p = 64'd1048576 - {44'd0, s.raw_pressure};
			p = ((p << 31) - y) * 64'd3125;
			an = p[63] ? -p : p;
			ad = x[63] ? -x : x;
			qq = an / ad;
			p = (p[63] != x[63]) ? -qq : qq;
			q = asr64(p, 13);
			e = asr64(p9 * q * q, 25);
			f = asr64(p8 * p, 19);
			p = asr64(p + e + f, 8) + (p7 << 4);
			r.pressure = p[31:0];
		end
		// humidity
		v = tfine - 32'd76800;
		g = asr32(({16'd0, s.raw_humidity} << 14) - (h4 << 20) - (h5 * v) + 32'd16384, 15);
		k = asr32(v * h6, 10);
		m = asr32(v * h3, 11) + 32'd32768;
		w = asr32(k * m, 10) + 32'd2097152;
		w = asr32(w * h2 + 32'd8192, 14);
		v = g * w;
		sq = asr32(v, 15);
		v = v - asr32(asr32(sq * sq, 7) * h1, 4);
		if (v[31])
			v = '0;
		else if (v > 32'd419430400)
			v = 32'd419430400;
		r.humidity = v[28:12];
		return r;
	endfunction

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			REG_TEMP:  temp_cal = val[47:0];
			REG_PLOW:  plow_cal = val;
			REG_PHIGH: phigh_cal = val;
			REG_P9:    p9_cal = val[15:0];
			REG_HUM:   hum_cal = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic load_cal(logic [63:0] tc, logic [63:0] pl, logic [63:0] ph,
			logic [63:0] p9v, logic [63:0] hc);
		write_reg(REG_TEMP, tc);
		write_reg(REG_PLOW, pl);
		write_reg(REG_PHIGH, ph);
		write_reg(REG_P9, p9v);
		write_reg(REG_HUM, hc);
	endtask

	// Stop offering, wait for the pipe to drain, then a little past the latency
	task automatic drain();
		in_valid <= 1'b0;
		while (sample_q.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// Offer one beat and hold it until accepted
	task automatic send_beat(in_item_t s);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= s;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sample_q.push_back(compensate(s));
		n_beats++;
	endtask

	function automatic in_item_t rand_sample();
		in_item_t s;
		s.raw_temperature = 20'($urandom_range(20'hFFFFF));
		s.raw_pressure = 20'($urandom_range(20'hFFFFF));
		s.raw_humidity = 16'($urandom_range(16'hFFFF));
		if ($urandom_range(3) != 0) begin
			// realistic region
			s.raw_temperature = 20'($urandom_range(400000, 600000));
			s.raw_pressure = 20'($urandom_range(250000, 450000));
			s.raw_humidity = 16'($urandom_range(20000, 40000));
		end
		return s;
	endfunction

	// Receiver: random stalls, plus a long hold-off when asked
	always @(posedge clk) begin
		if (hold_off)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(99) >= recv_idle);
	end

	// Result checker
	always @(posedge clk) begin
		out_item_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			if (sample_q.size() == 0) begin
				$display("%0t: result with nothing pending: %h", $time, out_data);
				errors++;
			end else begin
				exp_r = sample_q.pop_front();
				n_checked++;
				if (exp_r.pressure_div_zero)
					n_dz++;
				if (out_data.temperature !== exp_r.temperature) begin
					$display("%0t: temperature exp %0d got %0d", $time,
						exp_r.temperature, out_data.temperature);
					errors++;
				end
				if (out_data.pressure !== exp_r.pressure) begin
					$display("%0t: pressure exp %h got %h", $time,
						exp_r.pressure, out_data.pressure);
					errors++;
				end
				if (out_data.humidity !== exp_r.humidity) begin
					$display("%0t: humidity exp %0d got %0d", $time,
						exp_r.humidity, out_data.humidity);
					errors++;
				end
				if (out_data.pressure_div_zero !== exp_r.pressure_div_zero) begin
					$display("%0t: div_zero exp %b got %b", $time,
						exp_r.pressure_div_zero, out_data.pressure_div_zero);
					errors++;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > MAX_CYCLE) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	typedef struct {
		in_item_t  s;
		bit        known;
		out_item_t r;
	} dir_row_t;

	// Typical calibration set
	localparam logic [63:0] TC_TYP = {16'd0, 16'sd50, 16'sd26435, 16'd27504};
	localparam logic [63:0] PL_TYP = {16'sd2855, -16'sd3000 & 16'hFFFF,
		-16'sd10685 & 16'hFFFF, 16'd36477};
	localparam logic [63:0] PH_TYP = {16'sd4, -16'sd7 & 16'hFFFF, 16'sd15500, 16'sd140};

	initial begin
		dir_row_t rows[$];
		dir_row_t row;
		in_item_t s;
		temp_cal = '0; plow_cal = '0; phigh_cal = '0; p9_cal = '0; hum_cal = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset calibration: temperature, pressure and humidity all collapse
		row.known = 1'b1;
		row.r = '{temperature: 32'sd0, pressure: 32'd0, humidity: 17'd0,
			pressure_div_zero: 1'b1};
		row.s = '0; rows.push_back(row);
		row.s = '1; rows.push_back(row);
		row.s = '{raw_temperature: 20'hAAAAA, raw_pressure: 20'h55555,
			raw_humidity: 16'hA5A5};
		rows.push_back(row);
		foreach (rows[i]) begin
			send_beat(rows[i].s);
			// typed expectation replaces the predicted one
			if (rows[i].known)
				sample_q[sample_q.size() - 1] = rows[i].r;
		end
		drain();

		// Typical set, extremes of every field
		load_cal(TC_TYP, PL_TYP, PH_TYP, 64'd6000, {8'sd30, 12'sd50, 12'sd300,
			8'd0, 16'sd360, 8'd75});
		rows.delete();
		row.known = 1'b0;
		for (int i = 0; i < 8; i++) begin
			row.s.raw_temperature = i[0] ? 20'hFFFFF : 20'h00000;
			row.s.raw_pressure = i[1] ? 20'hFFFFF : 20'h00000;
			row.s.raw_humidity = i[2] ? 16'hFFFF : 16'h0000;
			rows.push_back(row);
		end
		row.s = '{raw_temperature: 20'd519888, raw_pressure: 20'd415148,
			raw_humidity: 16'd30000};
		rows.push_back(row);
		foreach (rows[i])
			send_beat(rows[i].s);
		drain();

		// Extreme coefficients: all ones, most negative, most positive
		load_cal('1, '1, '1, '1, '1);
		for (int i = 0; i < 4; i++)
			send_beat(rand_sample());
		drain();
		load_cal({16'h8000, 16'h8000, 16'hFFFF}, {4{16'h8000}} | 64'hFFFF,
			{4{16'h8000}}, 64'h8000, 64'h80_800_800_FF_8000_FF);
		for (int i = 0; i < 4; i++)
			send_beat(rand_sample());
		drain();
		load_cal({16'h7FFF, 16'h7FFF, 16'h0001}, {4{16'h7FFF}}, {4{16'h7FFF}},
			64'h7FFF, 64'h7F_7FF_7FF_00_7FFF_00);
		for (int i = 0; i < 4; i++)
			send_beat(rand_sample());
		drain();

		// Random part in three idling phases, new calibration each phase
		for (int ph = 0; ph < 3; ph++) begin
			send_idle = (ph == 0) ? 34 : (ph == 1) ? 75 : 0;
			recv_idle = (ph == 0) ? 75 : (ph == 1) ? 34 : 0;
			if (ph == 0)
				load_cal(TC_TYP, PL_TYP, PH_TYP, 64'd6000, {8'sd30, 12'sd50,
					12'sd300, 8'd0, 16'sd360, 8'd75});
			else
				load_cal({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
					{$urandom, $urandom}, {$urandom, $urandom});
			for (int i = 0; i < N_RANDOM / 3; i++) begin
				s = rand_sample();
				// once, in phase 1, zero the low pressure word to force the zero divisor region
				if (i == N_RANDOM / 6 && ph == 1) begin
					// sender pauses until all results are in
					drain();
					write_reg(REG_PLOW, {48'd0, 16'd0});
				end
				send_beat(s);
			end
			drain();
			if (ph == 2) begin
				// long receiver hold-off while the sender keeps offering
				hold_off = 1'b1;
				fork
					begin
						repeat (300) @(posedge clk);
						hold_off = 1'b0;
					end
					begin
						for (int i = 0; i < 120; i++)
							send_beat(rand_sample());
						drain();
					end
				join
			end
		end

		$display("Checked %0d of %0d sample beats, %0d with zero pressure divisor.",
			n_checked, n_beats, n_dz);
		if (errors == 0 && sample_q.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
